### hdl/chip8_cpu_core_macros.svh
// assertion macros for the chip8 core
// used by chip8_cpu_core; no other dependencies
`ifndef CHIP8_CPU_CORE_MACROS_SVH
`define CHIP8_CPU_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define CHIP8_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("chip8 assertion failed");
`define CHIP8_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("chip8 assertion failed");
`else
`define CHIP8_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CHIP8_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/chip8_pkg.sv
// shared types, constants and codes of the chip8 core
// no dependencies
package chip8_pkg;
    localparam int MEM_BYTES    = 4096;
    localparam int STACK_DEPTH  = 16;
    localparam int START_ADDR   = 512;
    localparam int FRAME_HEIGHT = 32;

    localparam int ADDR_W = $clog2(MEM_BYTES);
    localparam int PC_W   = 12;
    localparam int SP_W   = $clog2(STACK_DEPTH);
    localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
    localparam int ROW_W  = $clog2(FRAME_HEIGHT);

    typedef enum logic [2:0] {
        REQ_EXEC  = 3'd0,
        REQ_TICK  = 3'd1,
        REQ_KEY   = 3'd2,
        REQ_WRITE = 3'd3,
        REQ_ROW   = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_WAIT  = 2'd1,
        STAT_UNDEF = 2'd2,
        STAT_STACK = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        ALU_PASS, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SHL
    } alu_op_t;

    typedef struct packed {
        alu_op_t    op;
        logic [7:0] a;
        logic [7:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
    } alu_rsp_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_FETCH_HI, ST_FETCH_LO, ST_DECODE,
        ST_READ_X, ST_READ_Y, ST_EXEC, ST_BCD, ST_BCD_WR, ST_STORE,
        ST_LOAD_RD, ST_LOAD_WR, ST_DRAW_RD, ST_DRAW_WR, ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  key_index;
        logic        key_down;
        logic [11:0] mem_addr;
        logic [7:0]  mem_data;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] program_counter;
        logic [15:0] executed_opcode;
        logic        sound_on;
        logic [63:0] row_pixels;
    } rsp_t;
endpackage

### hdl/chip8_if.sv
// valid/ready channels of the chip8 core
// depends on chip8_pkg
interface chip8_req_if;
    logic              valid;
    logic              ready;
    chip8_pkg::req_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface chip8_rsp_if;
    logic              valid;
    logic              ready;
    chip8_pkg::rsp_t   data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/chip8_ram.sv
// generic single-port ram with registered read
// no dependencies
module chip8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### hdl/chip8_alu.sv
// shared 8-bit arithmetic, logic and shift unit
// depends on chip8_pkg
module chip8_alu (
    input  chip8_pkg::alu_req_t req,
    output chip8_pkg::alu_rsp_t rsp
);
    logic [8:0] sum;

    always_comb
    begin
        sum = {1'b0, req.a} + {1'b0, req.b};
        rsp = '0;
        unique case (req.op)
            chip8_pkg::ALU_PASS: rsp.res = req.b;
            chip8_pkg::ALU_OR:   rsp.res = req.a | req.b;
            chip8_pkg::ALU_AND:  rsp.res = req.a & req.b;
            chip8_pkg::ALU_XOR:  rsp.res = req.a ^ req.b;
            chip8_pkg::ALU_ADD:
            begin
                rsp.res  = sum[7:0];
                rsp.flag = sum[8];
            end
            chip8_pkg::ALU_SUB:
            begin
                rsp.res  = req.a - req.b;
                rsp.flag = (req.a >= req.b);
            end
            chip8_pkg::ALU_SHR:
            begin
                rsp.res  = {1'b0, req.a[7:1]};
                rsp.flag = req.a[0];
            end
            chip8_pkg::ALU_SHL:
            begin
                rsp.res  = {req.a[6:0], 1'b0};
                rsp.flag = req.a[7];
            end
            default: rsp = '0;
        endcase
    end
endmodule

### hdl/chip8_cpu_core.sv
// chip8 interpreter core: sequencer, register file, stack, framebuffer
// depends on chip8_pkg, chip8_if, chip8_ram, chip8_alu, chip8_cpu_core_macros.svh
//
// One request beat is taken at a time and answered by one result beat.
// After reset a clearing pass writes zero to all 4096 bytes of program
// memory before the first request is taken. Timer, key, memory write and
// row read requests pass through the start and done states. An instruction
// takes two fetch reads on the single memory port, two register reads,
// then execution. Longer ones: DXYN adds a read and a write state per
// sprite row, FX55 a store per register, FX65 a read and a write per register
// (memory port), FX33 loops as the shared 8-bit alu subtracts 100 and 10 in turn.
`include "chip8_cpu_core_macros.svh"
module chip8_cpu_core (
    input  logic              clk,
    input  logic              rst_n,
    chip8_req_if.sink         req,
    chip8_rsp_if.source       rsp
);
    localparam int AW = chip8_pkg::ADDR_W;
    localparam int PW = chip8_pkg::PC_W;

    chip8_pkg::state_t state_reg, state_next;

    chip8_pkg::req_t   in_reg;
    logic [15:0]       op_reg;
    logic [PW-1:0]     pc_reg;
    logic [PW-1:0]     i_reg;
    logic [7:0]        vx_reg, vy_reg;
    logic [7:0]        v_reg [16];
    logic [PW-1:0]     stack_reg [chip8_pkg::STACK_DEPTH];
    logic [chip8_pkg::DEP_W-1:0] depth_reg;
    logic [7:0]        delay_reg, sound_reg;
    logic [15:0]       keys_reg;
    logic [63:0]       frame_reg [chip8_pkg::FRAME_HEIGHT];
    logic [AW-1:0]     clr_reg;
    logic [3:0]        cnt_reg;
    logic              phase_reg;
    logic [3:0]        hund_reg, tens_reg;
    logic [7:0]        acc_reg;
    logic              hit_reg;
    chip8_pkg::status_t status_reg;
    logic [63:0]       row_reg;
    logic              is_exec_reg;
    logic              out_valid_reg;
    chip8_pkg::rsp_t   out_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [7:0]        ram_wdata, ram_rdata;
    chip8_pkg::alu_req_t alu_req;
    chip8_pkg::alu_rsp_t alu_rsp;

    logic [3:0]        rd_idx;
    logic [7:0]        rd_val;
    logic              v_we, vf_we;
    logic [3:0]        v_widx;
    logic [7:0]        v_wdata;
    logic              vf_data;
    chip8_pkg::status_t exec_status;

    logic [3:0]        op_x, op_y, op_n;
    logic [7:0]        op_nn;
    logic [3:0]        low_key;
    logic [chip8_pkg::ROW_W-1:0] draw_row, frow_idx;
    logic [63:0]       frow_val, sprite_mask;
    logic [127:0]      sprite_wide;
    logic              draw_hit, out_free, draw_last;

    assign op_x  = op_reg[11:8];
    assign op_y  = op_reg[7:4];
    assign op_n  = op_reg[3:0];
    assign op_nn = op_reg[7:0];

    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == chip8_pkg::ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    chip8_ram #(.WIDTH(8), .DEPTH(chip8_pkg::MEM_BYTES)) u_mem (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    chip8_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign rd_val = v_reg[rd_idx];

    // lowest pressed key
    always_comb
    begin
        low_key = '0;
        for (int k = 15; k >= 0; k--)
        begin
            if (keys_reg[k])
            begin
                low_key = 4'(k);
            end
        end
    end

    // sprite byte rotated onto its columns, wrapping at the right edge
    assign draw_row    = vy_reg[chip8_pkg::ROW_W-1:0] + chip8_pkg::ROW_W'(cnt_reg);
    assign frow_idx    = (state_reg == chip8_pkg::ST_START) ? in_reg.row_select : draw_row;
    assign frow_val    = frame_reg[frow_idx];
    assign sprite_wide = {ram_rdata, 56'd0, ram_rdata, 56'd0} >> vx_reg[5:0];
    assign sprite_mask = sprite_wide[63:0];
    assign draw_hit    = |(frow_val & sprite_mask);
    assign draw_last   = (cnt_reg == op_n - 4'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chip8_pkg::ST_CLEAR:
                if (&clr_reg) state_next = chip8_pkg::ST_IDLE;
            chip8_pkg::ST_IDLE:
                if (req.valid) state_next = chip8_pkg::ST_START;
            chip8_pkg::ST_START:
                state_next = (in_reg.req_type == chip8_pkg::REQ_EXEC) ?
                             chip8_pkg::ST_FETCH_HI : chip8_pkg::ST_DONE;
            chip8_pkg::ST_FETCH_HI: state_next = chip8_pkg::ST_FETCH_LO;
            chip8_pkg::ST_FETCH_LO: state_next = chip8_pkg::ST_DECODE;
            chip8_pkg::ST_DECODE:   state_next = chip8_pkg::ST_READ_X;
            chip8_pkg::ST_READ_X:   state_next = chip8_pkg::ST_READ_Y;
            chip8_pkg::ST_READ_Y:   state_next = chip8_pkg::ST_EXEC;
            chip8_pkg::ST_EXEC:
            begin
                state_next = chip8_pkg::ST_DONE;
                if (op_reg[15:12] == 4'hF && op_nn == 8'h33)
                    state_next = chip8_pkg::ST_BCD;
                else if (op_reg[15:12] == 4'hF && op_nn == 8'h55)
                    state_next = chip8_pkg::ST_STORE;
                else if (op_reg[15:12] == 4'hF && op_nn == 8'h65)
                    state_next = chip8_pkg::ST_LOAD_RD;
                else if (op_reg[15:12] == 4'hD && op_n != 4'd0)
                    state_next = chip8_pkg::ST_DRAW_RD;
            end
            chip8_pkg::ST_BCD:
                if (!alu_rsp.flag && phase_reg) state_next = chip8_pkg::ST_BCD_WR;
            chip8_pkg::ST_BCD_WR:
                if (cnt_reg == 4'd2) state_next = chip8_pkg::ST_DONE;
            chip8_pkg::ST_STORE:
                if (cnt_reg == op_x) state_next = chip8_pkg::ST_DONE;
            chip8_pkg::ST_LOAD_RD:  state_next = chip8_pkg::ST_LOAD_WR;
            chip8_pkg::ST_LOAD_WR:
                state_next = (cnt_reg == op_x) ? chip8_pkg::ST_DONE : chip8_pkg::ST_LOAD_RD;
            chip8_pkg::ST_DRAW_RD:  state_next = chip8_pkg::ST_DRAW_WR;
            chip8_pkg::ST_DRAW_WR:
                state_next = draw_last ? chip8_pkg::ST_DONE : chip8_pkg::ST_DRAW_RD;
            chip8_pkg::ST_DONE:
                if (out_free) state_next = chip8_pkg::ST_IDLE;
            default: state_next = chip8_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        ram_we      = 1'b0;
        ram_addr    = i_reg + AW'(cnt_reg);
        ram_wdata   = '0;
        alu_req.op  = chip8_pkg::ALU_PASS;
        alu_req.a   = vx_reg;
        alu_req.b   = op_nn;
        rd_idx      = op_x;
        v_we        = 1'b0;
        v_widx      = op_x;
        v_wdata     = alu_rsp.res;
        vf_we       = 1'b0;
        vf_data     = alu_rsp.flag;
        exec_status = chip8_pkg::STAT_OK;
        unique case (state_reg)
            chip8_pkg::ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_reg;
            end
            chip8_pkg::ST_START:
            begin
                ram_we    = (in_reg.req_type == chip8_pkg::REQ_WRITE);
                ram_addr  = in_reg.mem_addr;
                ram_wdata = in_reg.mem_data;
            end
            chip8_pkg::ST_FETCH_HI: ram_addr = pc_reg;
            chip8_pkg::ST_FETCH_LO: ram_addr = pc_reg + 12'd1;
            chip8_pkg::ST_READ_X:   rd_idx = op_x;
            chip8_pkg::ST_READ_Y:   rd_idx = (op_reg[15:12] == 4'hB) ? 4'd0 : op_y;
            chip8_pkg::ST_EXEC:
            begin
                unique case (op_reg[15:12])
                    4'h0:
                        if (op_reg != 16'h00E0 && op_reg != 16'h00EE)
                            exec_status = chip8_pkg::STAT_UNDEF;
                        else if (op_reg == 16'h00EE && depth_reg == '0)
                            exec_status = chip8_pkg::STAT_STACK;
                    4'h2:
                        if (depth_reg == chip8_pkg::DEP_W'(chip8_pkg::STACK_DEPTH))
                            exec_status = chip8_pkg::STAT_STACK;
                    4'h3, 4'h4: alu_req.op = chip8_pkg::ALU_SUB;
                    4'h5, 4'h9:
                    begin
                        alu_req.op = chip8_pkg::ALU_SUB;
                        alu_req.b  = vy_reg;
                    end
                    4'h6:
                    begin
                        v_we    = 1'b1;
                        v_wdata = op_nn;
                    end
                    4'h7:
                    begin
                        alu_req.op = chip8_pkg::ALU_ADD;
                        v_we       = 1'b1;
                    end
                    4'h8:
                    begin
                        alu_req.b = vy_reg;
                        v_we      = 1'b1;
                        vf_we     = 1'b1;
                        unique case (op_n)
                            4'h0:
                            begin
                                alu_req.op = chip8_pkg::ALU_PASS;
                                vf_we      = 1'b0;
                            end
                            4'h1:
                            begin
                                alu_req.op = chip8_pkg::ALU_OR;
                                vf_we      = 1'b0;
                            end
                            4'h2:
                            begin
                                alu_req.op = chip8_pkg::ALU_AND;
                                vf_we      = 1'b0;
                            end
                            4'h3:
                            begin
                                alu_req.op = chip8_pkg::ALU_XOR;
                                vf_we      = 1'b0;
                            end
                            4'h4: alu_req.op = chip8_pkg::ALU_ADD;
                            4'h5: alu_req.op = chip8_pkg::ALU_SUB;
                            4'h6: alu_req.op = chip8_pkg::ALU_SHR;
                            4'h7:
                            begin
                                alu_req.op = chip8_pkg::ALU_SUB;
                                alu_req.a  = vy_reg;
                                alu_req.b  = vx_reg;
                            end
                            4'hE: alu_req.op = chip8_pkg::ALU_SHL;
                            default:
                            begin
                                v_we        = 1'b0;
                                vf_we       = 1'b0;
                                exec_status = chip8_pkg::STAT_UNDEF;
                            end
                        endcase
                    end
                    4'hC:
                    begin
                        v_we    = 1'b1;
                        v_wdata = in_reg.random_byte & op_nn;
                    end
                    4'hD:
                        if (op_n == 4'd0)
                        begin
                            vf_we   = 1'b1;
                            vf_data = 1'b0;
                        end
                    4'hE:
                        if (op_nn != 8'h9E && op_nn != 8'hA1)
                            exec_status = chip8_pkg::STAT_UNDEF;
                    4'hF:
                        unique case (op_nn)
                            8'h07:
                            begin
                                v_we    = 1'b1;
                                v_wdata = delay_reg;
                            end
                            8'h0A:
                                if (keys_reg == '0)
                                    exec_status = chip8_pkg::STAT_WAIT;
                                else
                                begin
                                    v_we    = 1'b1;
                                    v_wdata = {4'd0, low_key};
                                end
                            8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65: ;
                            default: exec_status = chip8_pkg::STAT_UNDEF;
                        endcase
                    default: ;
                endcase
            end
            chip8_pkg::ST_BCD:
            begin
                alu_req.op = chip8_pkg::ALU_SUB;
                alu_req.a  = acc_reg;
                alu_req.b  = phase_reg ? 8'd10 : 8'd100;
            end
            chip8_pkg::ST_BCD_WR:
            begin
                ram_we = 1'b1;
                priority case (cnt_reg)
                    4'd0:    ram_wdata = {4'd0, hund_reg};
                    4'd1:    ram_wdata = {4'd0, tens_reg};
                    default: ram_wdata = acc_reg;
                endcase
            end
            chip8_pkg::ST_STORE:
            begin
                rd_idx    = cnt_reg;
                ram_we    = 1'b1;
                ram_wdata = rd_val;
            end
            chip8_pkg::ST_LOAD_WR:
            begin
                v_we    = 1'b1;
                v_widx  = cnt_reg;
                v_wdata = ram_rdata;
            end
            chip8_pkg::ST_DRAW_WR:
            begin
                vf_we   = draw_last;
                vf_data = hit_reg | draw_hit;
            end
            default: ;
        endcase
    end

    // register file, flag written last so it wins over vx
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 16; k++) v_reg[k] <= '0;
        end
        else
        begin
            if (v_we) v_reg[v_widx] <= v_wdata;
            if (vf_we) v_reg[15] <= {7'd0, vf_data};
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == chip8_pkg::ST_EXEC && op_reg[15:12] == 4'h2 &&
            exec_status == chip8_pkg::STAT_OK)
        begin
            stack_reg[depth_reg[chip8_pkg::SP_W-1:0]] <= pc_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) in_reg <= req.data;
        if (state_reg == chip8_pkg::ST_FETCH_LO) op_reg[15:8] <= ram_rdata;
        if (state_reg == chip8_pkg::ST_DECODE) op_reg[7:0] <= ram_rdata;
        if (state_reg == chip8_pkg::ST_READ_X) vx_reg <= rd_val;
        if (state_reg == chip8_pkg::ST_READ_Y) vy_reg <= rd_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= chip8_pkg::ST_CLEAR;
            pc_reg        <= PW'(chip8_pkg::START_ADDR);
            i_reg         <= '0;
            depth_reg     <= '0;
            delay_reg     <= '0;
            sound_reg     <= '0;
            keys_reg      <= '0;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            hund_reg      <= '0;
            tens_reg      <= '0;
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
            status_reg    <= chip8_pkg::STAT_OK;
            row_reg       <= '0;
            is_exec_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int k = 0; k < chip8_pkg::FRAME_HEIGHT; k++) frame_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && rsp.ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                chip8_pkg::ST_CLEAR: clr_reg <= clr_reg + AW'(1);
                chip8_pkg::ST_START:
                begin
                    status_reg  <= chip8_pkg::STAT_OK;
                    is_exec_reg <= (in_reg.req_type == chip8_pkg::REQ_EXEC);
                    row_reg     <= (in_reg.req_type == chip8_pkg::REQ_ROW) ? frow_val : '0;
                    if (in_reg.req_type == chip8_pkg::REQ_TICK)
                    begin
                        if (delay_reg != '0) delay_reg <= delay_reg - 8'd1;
                        if (sound_reg != '0) sound_reg <= sound_reg - 8'd1;
                    end
                    if (in_reg.req_type == chip8_pkg::REQ_KEY)
                        keys_reg[in_reg.key_index] <= in_reg.key_down;
                end
                chip8_pkg::ST_DECODE: pc_reg <= pc_reg + 12'd2;
                chip8_pkg::ST_EXEC:
                begin
                    status_reg <= exec_status;
                    cnt_reg    <= '0;
                    hit_reg    <= 1'b0;
                    phase_reg  <= 1'b0;
                    hund_reg   <= '0;
                    tens_reg   <= '0;
                    acc_reg    <= vx_reg;
                    unique case (op_reg[15:12])
                        4'h0:
                            if (op_reg == 16'h00E0)
                            begin
                                for (int k = 0; k < chip8_pkg::FRAME_HEIGHT; k++)
                                    frame_reg[k] <= '0;
                            end
                            else if (op_reg == 16'h00EE && depth_reg != '0)
                            begin
                                depth_reg <= depth_reg - chip8_pkg::DEP_W'(1);
                                pc_reg    <= stack_reg[chip8_pkg::SP_W'(depth_reg -
                                             chip8_pkg::DEP_W'(1))];
                            end
                        4'h1: pc_reg <= op_reg[11:0];
                        4'h2:
                            if (exec_status == chip8_pkg::STAT_OK)
                            begin
                                depth_reg <= depth_reg + chip8_pkg::DEP_W'(1);
                                pc_reg    <= op_reg[11:0];
                            end
                        4'h3, 4'h5:
                            if (alu_rsp.res == '0) pc_reg <= pc_reg + 12'd2;
                        4'h4, 4'h9:
                            if (alu_rsp.res != '0) pc_reg <= pc_reg + 12'd2;
                        4'hA: i_reg <= op_reg[11:0];
                        4'hB: pc_reg <= op_reg[11:0] + {4'd0, vy_reg};
                        4'hE:
                            if ((op_nn == 8'h9E && keys_reg[vx_reg[3:0]]) ||
                                (op_nn == 8'hA1 && !keys_reg[vx_reg[3:0]]))
                                pc_reg <= pc_reg + 12'd2;
                        4'hF:
                            unique case (op_nn)
                                8'h0A:
                                    if (keys_reg == '0) pc_reg <= pc_reg - 12'd2;
                                8'h15: delay_reg <= vx_reg;
                                8'h18: sound_reg <= vx_reg;
                                8'h1E: i_reg <= i_reg + {4'd0, vx_reg};
                                8'h29: i_reg <= {4'd0, vx_reg[3:0], 2'd0} +
                                                {8'd0, vx_reg[3:0]};
                                default: ;
                            endcase
                        default: ;
                    endcase
                end
                chip8_pkg::ST_BCD:
                    if (alu_rsp.flag)
                    begin
                        acc_reg <= alu_rsp.res;
                        if (phase_reg) tens_reg <= tens_reg + 4'd1;
                        else hund_reg <= hund_reg + 4'd1;
                    end
                    else
                    begin
                        phase_reg <= 1'b1;
                    end
                chip8_pkg::ST_BCD_WR: cnt_reg <= cnt_reg + 4'd1;
                chip8_pkg::ST_STORE, chip8_pkg::ST_LOAD_WR:
                    if (cnt_reg == op_x)
                        i_reg <= i_reg + {8'd0, op_x} + 12'd1;
                    else
                        cnt_reg <= cnt_reg + 4'd1;
                chip8_pkg::ST_DRAW_WR:
                begin
                    frame_reg[draw_row] <= frow_val ^ sprite_mask;
                    hit_reg <= hit_reg | draw_hit;
                    cnt_reg <= cnt_reg + 4'd1;
                end
                chip8_pkg::ST_DONE:
                    if (out_free)
                    begin
                        out_valid_reg           <= 1'b1;
                        out_reg.status          <= status_reg;
                        out_reg.program_counter <= pc_reg;
                        out_reg.executed_opcode <= is_exec_reg ? op_reg : 16'd0;
                        out_reg.sound_on        <= (sound_reg != '0);
                        out_reg.row_pixels      <= row_reg;
                    end
                default: ;
            endcase
        end
    end

    `CHIP8_ASSERT_IMP(a_depth_bound, clk, rst_n, 1'b1, depth_reg <= chip8_pkg::DEP_W'(chip8_pkg::STACK_DEPTH))
    `CHIP8_ASSERT_NXT(a_busy_after_beat, clk, rst_n, req.valid && req.ready, !req.ready)
    `CHIP8_ASSERT_IMP(a_no_write_idle, clk, rst_n, state_reg == chip8_pkg::ST_IDLE, !ram_we)
endmodule
